FILE: hw/rtl/mcps_pkg.sv
package mcps_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int WEIGHT_W  = 16;
    localparam int CAP_W     = 26;
    localparam int DAYS_W    = 11;
    localparam int GROUP_W   = CNT_W;

    localparam logic [DAYS_W-1:0] DAYS_RESET = DAYS_W'(1);

    // Controller to datapath
    typedef struct packed {
        logic accept;       // store one weight transaction
        logic init_bounds;  // low = max, high = sum
        logic pass_start;   // latch mid, rewind the pass
        logic pass_run;     // stream stored weights through the greedy count
        logic eval;         // move a bound after a finished pass
        logic finish;       // load the result register, clear per-set state
    } mcps_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic search_done;  // bounds have met
        logic pass_done;    // every stored weight counted
        logic out_busy;     // result register still holds an untaken result
    } mcps_stat_t;

endpackage

FILE: hw/rtl/min_capacity_partition_search.sv
// Load: one weight transaction per cycle, bounded by the single write port of the weight store.
// Search: starts after the last transaction; each of the bisection steps (at most 26) is a
//   check, a pass over the N stored weights and an update.
// Once a check sees the bounds met, the finish state loads the result register when it is free.
// Reset (aresetn, synchronous, active low) clears control and per-set state, days_allowed = 1;
//   the weight store itself is not cleared.
module min_capacity_partition_search
    import mcps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // weight input channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic                s_last,
    // days_allowed register
    input  logic                cfg_wr_en,
    input  logic [DAYS_W-1:0]   cfg_wr_data,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CAP_W-1:0]    m_capacity,
    output logic                m_overflow
);

    mcps_cmd_t  cmd;
    mcps_stat_t stat;

    // Controller: sequences loading, bound setup, the greedy counting passes and the bound
    // updates; hold the finished answer until the output register can take it.
    mcps_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_last (s_last),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // Datapath: weight store, running max and sum, bisection bounds, greedy group counter
    // fed by the store's registered read port, and the result register.
    mcps_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_weight   (s_weight),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_capacity (m_capacity),
        .m_overflow (m_overflow)
    );

endmodule

FILE: hw/rtl/mcps_ram.sv
module mcps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mcps_datapath.sv
module mcps_datapath
    import mcps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  mcps_cmd_t           cmd,
    output mcps_stat_t          stat,
    input  logic [WEIGHT_W-1:0] s_weight,
    input  logic                cfg_wr_en,
    input  logic [DAYS_W-1:0]   cfg_wr_data,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [CAP_W-1:0]    m_capacity,
    output logic                m_overflow
);

    logic [DAYS_W-1:0]   days_reg;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic [WEIGHT_W-1:0] max_reg,    max_next;
    logic [CAP_W-1:0]    total_reg,  total_next;
    logic                ovf_reg,    ovf_next;
    logic [CAP_W-1:0]    low_reg,    low_next;
    logic [CAP_W-1:0]    high_reg,   high_next;
    logic [CAP_W-1:0]    mid_reg,    mid_next;
    logic [CNT_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [GROUP_W-1:0]  groups_reg, groups_next;
    logic [CAP_W-1:0]    fill_reg,   fill_next;
    logic                mval_reg,   mval_next;
    logic [CAP_W-1:0]    mcap_reg,   mcap_next;
    logic                movf_reg,   movf_next;

    logic                store_full;
    logic                wr_en;
    logic                rd_issue;
    logic [WEIGHT_W-1:0] rd_data;
    logic [CAP_W:0]      fill_sum;
    logic [CAP_W:0]      bound_sum;

    mcps_ram #(
        .WIDTH(WEIGHT_W),
        .DEPTH(MAX_ITEMS)
    ) u_store (
        .clk  (aclk),
        .we   (wr_en),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(s_weight),
        .re   (rd_issue),
        .raddr(rd_ptr_reg[ADDR_W-1:0]),
        .rdata(rd_data)
    );

    assign store_full = (count_reg == CNT_W'(MAX_ITEMS));
    assign wr_en      = cmd.accept && !store_full;
    assign rd_issue   = cmd.pass_run && (rd_ptr_reg < count_reg);
    assign fill_sum   = {1'b0, fill_reg} + (CAP_W + 1)'(rd_data);
    assign bound_sum  = {1'b0, low_reg} + {1'b0, high_reg};

    always_comb begin
        count_next  = count_reg;
        max_next    = max_reg;
        total_next  = total_reg;
        ovf_next    = ovf_reg;
        low_next    = low_reg;
        high_next   = high_reg;
        mid_next    = mid_reg;
        rd_ptr_next = rd_ptr_reg;
        rd_vld_next = rd_issue;
        groups_next = groups_reg;
        fill_next   = fill_reg;
        mval_next   = mval_reg && !m_ready;
        mcap_next   = mcap_reg;
        movf_next   = movf_reg;

        if (cmd.accept) begin
            if (store_full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
                if (s_weight > max_reg) begin
                    max_next = s_weight;
                end
                total_next = total_reg + CAP_W'(s_weight);
            end
        end

        if (cmd.init_bounds) begin
            low_next  = CAP_W'(max_reg);
            high_next = total_reg;
        end

        if (cmd.pass_start) begin
            mid_next    = bound_sum[CAP_W:1];
            rd_ptr_next = '0;
            groups_next = GROUP_W'(1);
            fill_next   = '0;
        end

        if (rd_issue) begin
            rd_ptr_next = rd_ptr_reg + CNT_W'(1);
        end

        if (cmd.pass_run && rd_vld_reg) begin
            if (fill_sum > {1'b0, mid_reg}) begin
                groups_next = groups_reg + GROUP_W'(1);
                fill_next   = CAP_W'(rd_data);
            end else begin
                fill_next   = fill_sum[CAP_W-1:0];
            end
        end

        if (cmd.eval) begin
            if (groups_reg <= GROUP_W'(days_reg)) begin
                high_next = mid_reg;
            end else begin
                low_next  = mid_reg + CAP_W'(1);
            end
        end

        if (cmd.finish) begin
            mval_next  = 1'b1;
            mcap_next  = low_reg;
            movf_next  = ovf_reg;
            count_next = '0;
            max_next   = '0;
            total_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            days_reg   <= DAYS_RESET;
            count_reg  <= '0;
            max_reg    <= '0;
            total_reg  <= '0;
            ovf_reg    <= 1'b0;
            rd_vld_reg <= 1'b0;
            mval_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                days_reg <= cfg_wr_data;
            end
            count_reg  <= count_next;
            max_reg    <= max_next;
            total_reg  <= total_next;
            ovf_reg    <= ovf_next;
            rd_vld_reg <= rd_vld_next;
            mval_reg   <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        low_reg    <= low_next;
        high_reg   <= high_next;
        mid_reg    <= mid_next;
        rd_ptr_reg <= rd_ptr_next;
        groups_reg <= groups_next;
        fill_reg   <= fill_next;
        mcap_reg   <= mcap_next;
        movf_reg   <= movf_next;
    end

    assign stat.search_done = (low_reg >= high_reg);
    assign stat.pass_done   = (rd_ptr_reg == count_reg) && !rd_vld_reg;
    assign stat.out_busy    = mval_reg && !m_ready;

    assign m_valid    = mval_reg;
    assign m_capacity = mcap_reg;
    assign m_overflow = movf_reg;

endmodule

FILE: hw/rtl/mcps_ctrl.sv
module mcps_ctrl
    import mcps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_last,
    output logic       s_ready,
    input  mcps_stat_t stat,
    output mcps_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_SETUP  = 6'b000010,
        ST_CHECK  = 6'b000100,
        ST_PASS   = 6'b001000,
        ST_EVAL   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_LOAD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.accept      = accept;
        case (state_reg)
            ST_LOAD: begin
                if (accept && s_last) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.init_bounds = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.search_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.pass_start = 1'b1;
                    state_next     = ST_PASS;
                end
            end
            ST_PASS: begin
                cmd.pass_run = 1'b1;
                if (stat.pass_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
